### sv/mtep_pkg.sv
`timescale 1ns / 1ps
// mtep_pkg: shared types and codes for the midi track event parser
// no dependencies

package mtep_pkg;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  localparam logic [2:0] ERR_BAD_DELTA    = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED    = 3'd1;
  localparam logic [2:0] ERR_NO_RUNNING   = 3'd2;
  localparam logic [2:0] ERR_BAD_META     = 3'd3;
  localparam logic [2:0] ERR_ZERO_TEMPO   = 3'd4;
  localparam logic [2:0] ERR_BAD_SYSEX    = 3'd5;
  localparam logic [2:0] ERR_UNSUPPORTED  = 3'd6;

  localparam logic [7:0] META_STATUS   = 8'hFF;
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] SYSEX_START   = 8'hF0;
  localparam logic [7:0] SYSEX_ESCAPE  = 8'hF7;
  localparam logic [7:0] LAST_CHANNEL  = 8'hEF;

  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_POLY_AT  = 4'hA;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] abs_tick;
    logic [7:0]  status_value;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [23:0] tempo_us;
    logic        has_notes;
    logic [2:0]  error_code;
  } result_t;

  // one input byte's results: r0 always, r1 when two is set
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    two;
  } rec_t;

endpackage

### sv/mtep_front.sv
`timescale 1ns / 1ps
// mtep_front: byte classifier and track state machine, one byte per cycle while the queue is not full
// depends on mtep_pkg

module mtep_front #(
  parameter int TICK_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     data_i,
  input  logic           first_i,
  input  logic           last_i,
  input  logic           full_i,
  output logic           push_o,
  output mtep_pkg::rec_t rec_o
);
  import mtep_pkg::*;

  localparam logic [3:0] PH_DELTA     = 4'd0;
  localparam logic [3:0] PH_STATUS    = 4'd1;
  localparam logic [3:0] PH_DATA1     = 4'd2;
  localparam logic [3:0] PH_DATA2     = 4'd3;
  localparam logic [3:0] PH_META_TYPE = 4'd4;
  localparam logic [3:0] PH_META_LEN  = 4'd5;
  localparam logic [3:0] PH_SYSEX_LEN = 4'd6;
  localparam logic [3:0] PH_SKIP      = 4'd7;
  localparam logic [3:0] PH_TEMPO     = 4'd8;

  localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

  logic [3:0]            ph_q, ph_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d;
  logic [7:0]            rs_q, rs_d;
  logic [7:0]            evs_q, evs_d;
  logic [7:0]            hfd_q, hfd_d;
  logic [27:0]           vacc_q, vacc_d;
  logic [1:0]            vcnt_q, vcnt_d;
  logic [7:0]            mk_q, mk_d;
  logic [27:0]           skip_q, skip_d;
  logic [23:0]           tacc_q, tacc_d;
  logic [1:0]            tidx_q, tidx_d;
  logic                  notes_q, notes_d;
  logic                  halt_q, halt_d;

  logic                  fire;
  logic                  vlq_done, vlq_long;
  logic [TICK_WIDTH:0]   tick_sum;
  logic [3:0]            ev_type;
  logic                  emit_a, emit_b;
  result_t               res_a, res_b;
  logic [2:0]            cut;

  assign in_ready_o = !full_i;
  assign fire       = in_valid_i && !full_i;

  always_comb begin
    ph_d     = ph_q;
    tick_d   = tick_q;
    rs_d     = rs_q;
    evs_d    = evs_q;
    hfd_d    = hfd_q;
    vacc_d   = vacc_q;
    vcnt_d   = vcnt_q;
    mk_d     = mk_q;
    skip_d   = skip_q;
    tacc_d   = tacc_q;
    tidx_d   = tidx_q;
    notes_d  = notes_q;
    halt_d   = halt_q;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    res_a    = '0;
    res_b    = '0;
    vlq_done = 1'b0;
    vlq_long = 1'b0;
    tick_sum = '0;
    ev_type  = '0;
    cut      = ERR_TRUNCATED;

    if (first_i) begin
      ph_d    = PH_DELTA;
      tick_d  = '0;
      rs_d    = '0;
      evs_d   = '0;
      hfd_d   = '0;
      vacc_d  = '0;
      vcnt_d  = '0;
      mk_d    = '0;
      skip_d  = '0;
      tacc_d  = '0;
      tidx_d  = '0;
      notes_d = 1'b0;
      halt_d  = 1'b0;
    end

    if (!halt_d) begin
      // shared quantity decoder for delta, meta and sysex lengths
      if (ph_d == PH_DELTA || ph_d == PH_META_LEN || ph_d == PH_SYSEX_LEN) begin
        vacc_d = {vacc_d[20:0], data_i[6:0]};
        if (!data_i[7]) begin
          vlq_done = 1'b1;
          vcnt_d   = '0;
        end else if (vcnt_d == 2'd3) begin
          vlq_long = 1'b1;
          vcnt_d   = '0;
        end else begin
          vcnt_d = vcnt_d + 2'd1;
        end
      end

      case (ph_d)
        PH_DELTA: begin
          if (vlq_long) begin
            halt_d         = 1'b1;
            emit_a         = 1'b1;
            res_a.kind       = KIND_ERROR;
            res_a.error_code = ERR_BAD_DELTA;
          end else if (vlq_done) begin
            tick_sum = {1'b0, tick_d} + (TICK_WIDTH+1)'(vacc_d);
            tick_d   = tick_sum[TICK_WIDTH] ? TICK_MAX : tick_sum[TICK_WIDTH-1:0];
            ph_d     = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (!data_i[7]) begin
            if (rs_d == '0) begin
              halt_d           = 1'b1;
              emit_a           = 1'b1;
              res_a.kind       = KIND_ERROR;
              res_a.error_code = ERR_NO_RUNNING;
            end else begin
              evs_d   = rs_d;
              hfd_d   = data_i;
              ev_type = rs_d[7:4];
              if (ev_type == TYPE_PROGRAM || ev_type == TYPE_PRESSURE) begin
                ph_d   = PH_DELTA;
                vacc_d = '0;
                vcnt_d = '0;
              end else begin
                ph_d = PH_DATA2;
              end
            end
          end else begin
            if (data_i <= LAST_CHANNEL) rs_d = data_i;
            evs_d = data_i;
            if (data_i == META_STATUS) begin
              ph_d = PH_META_TYPE;
            end else if (data_i == SYSEX_START || data_i == SYSEX_ESCAPE) begin
              vacc_d = '0;
              vcnt_d = '0;
              ph_d   = PH_SYSEX_LEN;
            end else if (data_i > LAST_CHANNEL) begin
              halt_d           = 1'b1;
              emit_a           = 1'b1;
              res_a.kind       = KIND_ERROR;
              res_a.error_code = ERR_UNSUPPORTED;
            end else begin
              ph_d = PH_DATA1;
            end
          end
        end
        PH_DATA1: begin
          hfd_d   = data_i;
          ev_type = evs_d[7:4];
          if (ev_type == TYPE_PROGRAM || ev_type == TYPE_PRESSURE) begin
            ph_d   = PH_DELTA;
            vacc_d = '0;
            vcnt_d = '0;
          end else begin
            ph_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          ev_type = evs_d[7:4];
          if (ev_type != TYPE_POLY_AT) begin
            if (ev_type == TYPE_NOTE_OFF || ev_type == TYPE_NOTE_ON) notes_d = 1'b1;
            emit_a             = 1'b1;
            res_a.kind         = KIND_CHANNEL;
            res_a.abs_tick     = 32'(tick_d);
            res_a.status_value = evs_d;
            res_a.first_data   = hfd_d;
            res_a.second_data  = data_i;
          end
          ph_d   = PH_DELTA;
          vacc_d = '0;
          vcnt_d = '0;
        end
        PH_META_TYPE: begin
          mk_d   = data_i;
          vacc_d = '0;
          vcnt_d = '0;
          ph_d   = PH_META_LEN;
        end
        PH_META_LEN: begin
          if (vlq_long) begin
            halt_d           = 1'b1;
            emit_a           = 1'b1;
            res_a.kind       = KIND_ERROR;
            res_a.error_code = ERR_BAD_META;
          end else if (vlq_done) begin
            if (mk_d == META_TEMPO && vacc_d == 28'd3) begin
              tacc_d = '0;
              tidx_d = '0;
              ph_d   = PH_TEMPO;
            end else if (vacc_d == '0) begin
              if (evs_d == META_STATUS && mk_d == META_END) begin
                halt_d          = 1'b1;
                emit_a          = 1'b1;
                res_a.kind      = KIND_END;
                res_a.abs_tick  = 32'(tick_d);
                res_a.has_notes = notes_d;
              end else begin
                ph_d   = PH_DELTA;
                vacc_d = '0;
                vcnt_d = '0;
              end
            end else begin
              skip_d = vacc_d;
              ph_d   = PH_SKIP;
            end
          end
        end
        PH_SYSEX_LEN: begin
          if (vlq_long) begin
            halt_d           = 1'b1;
            emit_a           = 1'b1;
            res_a.kind       = KIND_ERROR;
            res_a.error_code = ERR_BAD_SYSEX;
          end else if (vlq_done) begin
            if (vacc_d == '0) begin
              ph_d   = PH_DELTA;
              vacc_d = '0;
              vcnt_d = '0;
            end else begin
              skip_d = vacc_d;
              ph_d   = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (skip_d != '0) skip_d = skip_d - 28'd1;
          if (skip_d == '0) begin
            if (evs_d == META_STATUS && mk_d == META_END) begin
              halt_d          = 1'b1;
              emit_a          = 1'b1;
              res_a.kind      = KIND_END;
              res_a.abs_tick  = 32'(tick_d);
              res_a.has_notes = notes_d;
            end else begin
              ph_d   = PH_DELTA;
              vacc_d = '0;
              vcnt_d = '0;
            end
          end
        end
        PH_TEMPO: begin
          tacc_d = {tacc_d[15:0], data_i};
          tidx_d = tidx_d + 2'd1;
          if (tidx_d == 2'd3) begin
            tidx_d = '0;
            if (tacc_d == '0) begin
              halt_d           = 1'b1;
              emit_a           = 1'b1;
              res_a.kind       = KIND_ERROR;
              res_a.error_code = ERR_ZERO_TEMPO;
            end else begin
              emit_a         = 1'b1;
              res_a.kind     = KIND_TEMPO;
              res_a.abs_tick = 32'(tick_d);
              res_a.tempo_us = tacc_d;
              ph_d           = PH_DELTA;
              vacc_d         = '0;
              vcnt_d         = '0;
            end
          end
        end
        default: begin
          ph_d   = PH_DELTA;
          vacc_d = '0;
          vcnt_d = '0;
        end
      endcase

      case (ph_d)
        PH_DELTA:                          cut = ERR_BAD_DELTA;
        PH_SYSEX_LEN:                      cut = ERR_BAD_SYSEX;
        PH_META_TYPE, PH_META_LEN, PH_TEMPO: cut = ERR_BAD_META;
        PH_SKIP:   cut = (evs_d == META_STATUS) ? ERR_BAD_META : ERR_BAD_SYSEX;
        default:                           cut = ERR_TRUNCATED;
      endcase

      if (!halt_d && last_i) begin
        halt_d = 1'b1;
        emit_b = 1'b1;
        if (ph_d == PH_DELTA && vcnt_d == '0) begin
          res_b.kind      = KIND_END;
          res_b.abs_tick  = 32'(tick_d);
          res_b.has_notes = notes_d;
        end else begin
          res_b.kind       = KIND_ERROR;
          res_b.error_code = cut;
        end
      end
    end
  end

  always_comb begin
    rec_o = '0;
    if (emit_a) begin
      rec_o.r0  = res_a;
      rec_o.r1  = res_b;
      rec_o.two = emit_b;
    end else begin
      rec_o.r0 = res_b;
    end
  end

  assign push_o = fire && (emit_a || emit_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_DELTA;
      tick_q  <= '0;
      rs_q    <= '0;
      evs_q   <= '0;
      hfd_q   <= '0;
      vacc_q  <= '0;
      vcnt_q  <= '0;
      mk_q    <= '0;
      skip_q  <= '0;
      tacc_q  <= '0;
      tidx_q  <= '0;
      notes_q <= 1'b0;
      halt_q  <= 1'b1;
    end else if (fire) begin
      ph_q    <= ph_d;
      tick_q  <= tick_d;
      rs_q    <= rs_d;
      evs_q   <= evs_d;
      hfd_q   <= hfd_d;
      vacc_q  <= vacc_d;
      vcnt_q  <= vcnt_d;
      mk_q    <= mk_d;
      skip_q  <= skip_d;
      tacc_q  <= tacc_d;
      tidx_q  <= tidx_d;
      notes_q <= notes_d;
      halt_q  <= halt_d;
    end
  end

endmodule

### sv/mtep_queue.sv
`timescale 1ns / 1ps
// mtep_queue: small register queue of per-byte result records
// depends on mtep_pkg

module mtep_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mtep_pkg::rec_t rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mtep_pkg::rec_t rec_o
);
  import mtep_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rec_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + AW'(1);
      if (do_pop)  rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + AW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + CW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

### sv/mtep_back.sv
`timescale 1ns / 1ps
// mtep_back: splits queued records into single result beats behind an output register
// depends on mtep_pkg

module mtep_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  mtep_pkg::rec_t    q_rec_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtep_pkg::result_t out_res_o,
  output logic              out_last_o
);
  import mtep_pkg::*;

  logic    sub_q, sub_d;
  logic    vld_q, vld_d;
  result_t res_q, res_d;
  logic    last_q, last_d;
  logic    load;

  assign load = !vld_q || out_ready_i;

  always_comb begin
    sub_d   = sub_q;
    vld_d   = vld_q;
    res_d   = res_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (load) begin
      vld_d = q_valid_i;
      if (q_valid_i) begin
        res_d  = sub_q ? q_rec_i.r1 : q_rec_i.r0;
        last_d = sub_q || !q_rec_i.two;
        if (q_rec_i.two && !sub_q) begin
          sub_d = 1'b1;
        end else begin
          sub_d   = 1'b0;
          q_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    last_q <= last_d;
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;
  assign out_last_o  = last_q;

endmodule

### sv/midi_track_event_parser.sv
`timescale 1ns / 1ps
// midi_track_event_parser: streaming track chunk parser, top level
// depends on mtep_pkg, mtep_front, mtep_queue, mtep_back
//
// channel  dir  beat contents
// s_axis   in   tdata[7:0] track byte, tuser first byte of track, tlast last byte of track
// m_axis   out  tdata result fields, tuser kind, tlast last result of its input byte
//
// one byte is taken per cycle while the record queue has room
// a byte's results leave one per cycle while m_axis_tready is high, so a byte with two results takes two output beats
// a byte's first result passes from the front into the queue, then from the queue into the output register
// reset leaves the parser halted until a byte flagged first; no clearing pass
// output stalls fill the queue, then s_axis_tready drops

module midi_track_event_parser #(
  parameter int TICK_WIDTH  = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [0:0]  s_axis_tuser,   // first_in_track
  input  logic        s_axis_tlast,   // last_in_track
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // abs_tick[31:0], status_value[39:32], first_data[47:40], second_data[55:48],
  // tempo_us[79:56], has_notes[80], error_code[83:81], zero fill[87:84]
  output logic [87:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last_of_run
);
  import mtep_pkg::*;

  logic    push, full, pop, q_valid;
  rec_t    rec_in, rec_out;
  result_t res;

  mtep_front #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .data_i    (s_axis_tdata),
    .first_i   (s_axis_tuser[0]),
    .last_i    (s_axis_tlast),
    .full_i    (full),
    .push_o    (push),
    .rec_o     (rec_in)
  );

  mtep_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec_in),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .rec_o  (rec_out)
  );

  mtep_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_rec_i    (rec_out),
    .q_pop_o    (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res),
    .out_last_o (m_axis_tlast)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {4'b0, res.error_code, res.has_notes, res.tempo_us,
                         res.second_data, res.first_data, res.status_value, res.abs_tick};

endmodule
